FILE: rtl/bpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg: shared definitions for the bitplane to palette pixel converter
// Opcodes, default palette colors, the pixel cell record and color helpers.
// ----------------------------------------------------------------------------
package bpp_pkg;

    // tuser opcodes
    localparam logic [1:0] OP_WR_RGB24 = 2'd0;
    localparam logic [1:0] OP_WR_RGB4  = 2'd1;
    localparam logic [1:0] OP_CONVERT  = 2'd2;

    localparam int PIXELS           = 8;
    localparam int PLANES           = 8;
    localparam int MAX_PLANES       = 8;
    localparam int PALETTE_ENTRIES  = 256;
    localparam logic [3:0] ACTIVE_PLANES_RST = 4'd4;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // fixed colors of the first four entries after reset
    localparam logic [23:0] DFLT_COLOR0 = 24'h9999BB;
    localparam logic [23:0] DFLT_COLOR1 = 24'h000000;
    localparam logic [23:0] DFLT_COLOR2 = 24'hFFFFFF;
    localparam logic [23:0] DFLT_COLOR3 = 24'h0055AA;

    // one pixel slot in the shift chain
    typedef struct packed {
        logic       vld;
        logic       last;
        logic [7:0] idx;
    } cell_t;

    // 0xRGB -> 0xRRGGBB, each nibble times 17
    function automatic logic [23:0] rgb4_expand(input logic [11:0] rgb4);
        return {rgb4[11:8], rgb4[11:8], rgb4[7:4], rgb4[7:4], rgb4[3:0], rgb4[3:0]};
    endfunction

endpackage

FILE: rtl/bpp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_ram: generic single-write, single-read RAM
// Registered read; a read and write to one address return the old data.
// ----------------------------------------------------------------------------
module bpp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bpp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_cell: one pixel slot of the output shift chain
// Loads its plane-bit column on a new group, else on shift takes its neighbor.
// ----------------------------------------------------------------------------
module bpp_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           shift,
    input  logic [7:0]     col_bits,   // bit p = plane p at this column
    input  logic [7:0]     plane_mask, // planes that count toward the index
    input  logic           load_last,
    input  bpp_pkg::cell_t nbr,
    output bpp_pkg::cell_t q
);

    bpp_pkg::cell_t cell_reg;
    bpp_pkg::cell_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (load)
        begin
            cell_next.vld  = 1'b1;
            cell_next.last = load_last;
            cell_next.idx  = col_bits & plane_mask;
        end
        else if (shift)
        begin
            cell_next = nbr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

FILE: rtl/bitplane_to_palette_pixels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_to_palette_pixels: planar to chunky converter with palette lookup
// Eight plane bytes in, eight ARGB pixels out, MSB column first.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser: op; tdata: palette_index,
//                                             color_value, plane_bits_0..7,
//                                             plane_present
//  m_axis    out  m_axis_tvalid/tready        tdata: pixel_argb, pixel_index;
//                                             tlast: last_pixel
//  cfg       in   cfg_wr_en (no back-press.)  cfg_wr_data: active_planes
//
//  Palette writes take one transfer. A convert transfer loads all eight
//  pixel indexes into an eight-cell shift chain in parallel; the chain then
//  feeds one index per cycle, unless m_axis stalls, into the single
//  palette read port. The next convert is taken as the last pixel leaves
//  the chain. Pixels go from chain head to read stage to output register.
//  Reset restores the default palette at once through per-entry valid bits
//  (an entry never written reads its default color); no clearing pass.
//  An m_axis stall freezes the chain, the read stage and the output register
//  together; input is held off while more than one pixel is still queued.
//
module bitplane_to_palette_pixels #(
    parameter int PALETTE_ENTRIES = bpp_pkg::PALETTE_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data,    // active_planes
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] palette_index, [31:8] color_value, [39:32] plane_bits_0, ...,
    // [95:88] plane_bits_7, [103:96] plane_present
    input  logic [103:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // [31:0] pixel_argb, [39:32] pixel_index
    output logic         m_axis_tlast    // last_pixel
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] ENTRIES_W = 9'(PALETTE_ENTRIES);
    localparam logic [3:0] MAX_PLANES_W = 4'(bpp_pkg::MAX_PLANES);

    // ------------------------------------------------------------------
    // input unpack
    // ------------------------------------------------------------------
    logic [1:0]  in_op;
    logic [7:0]  in_pal_idx;
    logic [23:0] in_color;
    logic [7:0]  in_present;
    logic [7:0]  plane_bits [bpp_pkg::PLANES];

    assign in_op      = s_axis_tuser;
    assign in_pal_idx = s_axis_tdata[7:0];
    assign in_color   = s_axis_tdata[31:8];
    assign in_present = s_axis_tdata[103:96];

    for (genvar p = 0; p < bpp_pkg::PLANES; p++)
    begin : g_planes
        assign plane_bits[p] = s_axis_tdata[32 + 8*p +: 8];
    end

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [3:0] active_planes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_planes_reg <= bpp_pkg::ACTIVE_PLANES_RST;
        end
        else if (cfg_wr_en)
        begin
            active_planes_reg <= cfg_wr_data;
        end
    end

    // depth clamp and the planes that feed the index
    logic [3:0] depth_eff;
    logic [7:0] plane_mask;

    always_comb
    begin
        depth_eff = (active_planes_reg > MAX_PLANES_W) ? MAX_PLANES_W : active_planes_reg;
        for (int p = 0; p < bpp_pkg::PLANES; p++)
        begin
            plane_mask[p] = in_present[p] && (4'(p) < depth_eff);
        end
    end

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    bpp_pkg::cell_t chain_q [bpp_pkg::PIXELS];
    logic           out_vld_reg;
    logic           adv;       // whole pipeline moves this cycle
    logic           xfer_in;
    logic           conv_load;
    logic           pal_wr;
    logic [23:0]    pal_wdata;

    assign adv           = !out_vld_reg || m_axis_tready;
    // at most one queued pixel, and it leaves at this edge
    assign s_axis_tready = adv && !chain_q[1].vld;
    assign xfer_in       = s_axis_tvalid && s_axis_tready;
    assign conv_load     = xfer_in && (in_op == bpp_pkg::OP_CONVERT);
    // writes past the palette end are dropped; opcode 3 does nothing
    assign pal_wr        = xfer_in && ({1'b0, in_pal_idx} < ENTRIES_W)
                           && ((in_op == bpp_pkg::OP_WR_RGB24)
                           || (in_op == bpp_pkg::OP_WR_RGB4));
    assign pal_wdata     = (in_op == bpp_pkg::OP_WR_RGB4)
                           ? bpp_pkg::rgb4_expand(in_color[11:0]) : in_color;

    // ------------------------------------------------------------------
    // pixel chain: cell k holds the pixel of column 7-k; cell 0 is the head
    // ------------------------------------------------------------------
    for (genvar k = 0; k < bpp_pkg::PIXELS; k++)
    begin : g_cells
        logic [7:0]     col_bits;
        bpp_pkg::cell_t nbr;

        for (genvar p = 0; p < bpp_pkg::PLANES; p++)
        begin : g_col
            assign col_bits[p] = plane_bits[p][bpp_pkg::PIXELS - 1 - k];
        end

        if (k == bpp_pkg::PIXELS - 1)
        begin : g_tail
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = chain_q[k + 1];
        end

        bpp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (conv_load),
            .shift      (adv),
            .col_bits   (col_bits),
            .plane_mask (plane_mask),
            .load_last  (1'(k == bpp_pkg::PIXELS - 1)),
            .nbr        (nbr),
            .q          (chain_q[k])
        );
    end

    // ------------------------------------------------------------------
    // palette: RAM plus per-entry written bits; unwritten entries read default
    // ------------------------------------------------------------------
    logic [23:0] dflt_tab [PALETTE_ENTRIES];

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_dflt
        localparam int GRAY = (i * 255) / (PALETTE_ENTRIES - 1);
        localparam logic [7:0] G8 = 8'(GRAY);
        if (i == 0)
        begin : g_c0
            assign dflt_tab[i] = bpp_pkg::DFLT_COLOR0;
        end
        else if (i == 1)
        begin : g_c1
            assign dflt_tab[i] = bpp_pkg::DFLT_COLOR1;
        end
        else if (i == 2)
        begin : g_c2
            assign dflt_tab[i] = bpp_pkg::DFLT_COLOR2;
        end
        else if (i == 3)
        begin : g_c3
            assign dflt_tab[i] = bpp_pkg::DFLT_COLOR3;
        end
        else
        begin : g_ramp
            assign dflt_tab[i] = {G8, G8, G8};
        end
    end

    logic [PALETTE_ENTRIES-1:0] pal_written_reg;
    logic [AW-1:0]              rd_addr;
    logic [23:0]                ram_rdata;

    assign rd_addr = chain_q[0].idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_written_reg <= '0;
        end
        else if (pal_wr)
        begin
            pal_written_reg[in_pal_idx[AW-1:0]] <= 1'b1;
        end
    end

    bpp_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_wr),
        .waddr (in_pal_idx[AW-1:0]),
        .wdata (pal_wdata),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // read stage: runs alongside the RAM read register (old data on collision)
    // ------------------------------------------------------------------
    bpp_pkg::cell_t rd_reg;
    logic           rd_inrng_reg;
    logic           rd_written_reg;
    logic [23:0]    rd_dflt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
        end
        else if (adv)
        begin
            rd_reg <= chain_q[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_inrng_reg   <= ({1'b0, chain_q[0].idx} < ENTRIES_W);
            rd_written_reg <= pal_written_reg[rd_addr];
            rd_dflt_reg    <= dflt_tab[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [31:0] out_argb_reg;
    logic [31:0] out_argb_next;
    logic [7:0]  out_idx_reg;
    logic        out_last_reg;
    logic [23:0] rgb_sel;

    always_comb
    begin
        rgb_sel = rd_written_reg ? ram_rdata : rd_dflt_reg;
        // index past the palette end gives opaque black
        out_argb_next = {bpp_pkg::ALPHA_OPAQUE, rd_inrng_reg ? rgb_sel : 24'h000000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= rd_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_argb_reg <= out_argb_next;
            out_idx_reg  <= rd_reg.idx;
            out_last_reg <= rd_reg.last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_idx_reg, out_argb_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/bpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_checker: port-level checks for the bitplane to palette pixel converter
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bpp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic         m_axis_tlast
);

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // every pixel is opaque
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:24] == 8'hFF)
        else $error("pixel alpha is not opaque");

    // a convert fills the chain, so no transfer is taken the next cycle
    a_busy_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == bpp_pkg::OP_CONVERT
            |=> !s_axis_tready)
        else $error("input ready right after a convert transfer");

    // pixels of one group come back to back
    a_group_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a pixel group");

endmodule

bind bitplane_to_palette_pixels bpp_checker u_bpp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the bitplane to palette pixel converter
// Palette writes and plane-byte conversions stream in at random pace; a
// shadow palette and plane depth predict every pixel, which is checked field
// by field as it leaves, with random back-pressure and several depth settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED    = 2'd3;   // no function, must be dropped
    localparam int         IDLE_PCT     = 29;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE       = 8;      // cycles after the last pixel
    localparam int         PHASE_ITEMS  = 36;

    typedef struct packed {
        logic [1:0]      op;
        logic [7:0]      slot;      // palette entry for writes
        logic [23:0]     color;
        logic [7:0][7:0] planes;    // planes[k] is the byte of plane k
        logic [7:0]      present;
    } plane_req_t;

    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  idx;
        logic        last;
    } pixel_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [3:0]   cfg_wr_data   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;

    plane_req_t  req_q[$];      // items not yet offered
    plane_req_t  req_on_bus;    // item currently offered on s_axis
    pixel_t      pixel_q[$];    // pixels still owed by the block, oldest first
    pixel_t      pixel_due;
    logic [23:0] shadow_pal [bpp_pkg::PALETTE_ENTRIES];
    logic [3:0]  shadow_depth;
    logic        steady = 1'b0; // both sides run without gaps while set
    int          errors = 0;
    int          cycles = 0;

    bitplane_to_palette_pixels u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- shadow of the block ------------------------------------------------

    // grey ramp, four fixed colors on top, depth back to 4
    function automatic void palette_defaults();
        for (int i = 0; i < bpp_pkg::PALETTE_ENTRIES; i++)
        begin
            logic [7:0] grey;
            grey = 8'((i * 255) / (bpp_pkg::PALETTE_ENTRIES - 1));
            shadow_pal[i] = {grey, grey, grey};
        end
        shadow_pal[0] = 24'h9999BB;
        shadow_pal[1] = 24'h000000;
        shadow_pal[2] = 24'hFFFFFF;
        shadow_pal[3] = 24'h0055AA;
        shadow_depth  = 4'd4;
    endfunction

    // apply one accepted transfer: palette update, eight owed pixels or nothing
    function automatic void absorb(plane_req_t r);
        int          depth;
        logic [7:0]  idx;
        logic [7:0]  red, green, blue;
        logic [23:0] rgb;
        case (r.op)
            bpp_pkg::OP_WR_RGB24:
            begin
                if (r.slot < bpp_pkg::PALETTE_ENTRIES)
                    shadow_pal[r.slot] = r.color;
            end
            bpp_pkg::OP_WR_RGB4:
            begin
                // only the low twelve bits count; nibble * 17 fills a byte
                red   = 8'(r.color[11:8] * 17);
                green = 8'(r.color[7:4] * 17);
                blue  = 8'(r.color[3:0] * 17);
                if (r.slot < bpp_pkg::PALETTE_ENTRIES)
                    shadow_pal[r.slot] = {red, green, blue};
            end
            bpp_pkg::OP_CONVERT:
            begin
                depth = (shadow_depth > bpp_pkg::MAX_PLANES) ? bpp_pkg::MAX_PLANES
                                                             : int'(shadow_depth);
                for (int px = 0; px < 8; px++)
                begin
                    idx = '0;
                    for (int p = 0; p < depth; p++)
                        if (r.present[p] && r.planes[p][7 - px])
                            idx[p] = 1'b1;
                    // index past the palette end gives opaque black
                    rgb = (idx < bpp_pkg::PALETTE_ENTRIES) ? shadow_pal[idx] : 24'h000000;
                    pixel_q.push_back('{argb: {8'hFF, rgb}, idx: idx,
                                        last: (px == 7)});
                end
            end
            default: ;  // unused opcode: nothing happens
        endcase
    endfunction

    // ---- driver: offers queued items on s_axis ------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                absorb(req_on_bus);     // transfer done at this edge
            if (req_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                req_on_bus = req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {req_on_bus.present, req_on_bus.planes,
                                  req_on_bus.color, req_on_bus.slot};
                s_axis_tuser  <= req_on_bus.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---- monitor: checks each pixel transfer on m_axis ----------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_q.size() == 0)
                    report_mismatch("unexpected pixel", m_axis_tdata[31:0], '0);
                else
                begin
                    pixel_due = pixel_q.pop_front();
                    if (m_axis_tdata[31:0] !== pixel_due.argb)
                        report_mismatch("pixel_argb", m_axis_tdata[31:0], pixel_due.argb);
                    if (m_axis_tdata[39:32] !== pixel_due.idx)
                        report_mismatch("pixel_index", 32'(m_axis_tdata[39:32]),
                                        32'(pixel_due.idx));
                    if (m_axis_tlast !== pixel_due.last)
                        report_mismatch("last_pixel", 32'(m_axis_tlast),
                                        32'(pixel_due.last));
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---- watchdog -----------------------------------------------------------

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---- stimulus -----------------------------------------------------------

    function automatic plane_req_t mk_req(logic [1:0] op, logic [7:0] slot,
                                          logic [23:0] color, logic [63:0] planes,
                                          logic [7:0] present);
        plane_req_t r;
        r.op      = op;
        r.slot    = slot;
        r.color   = color;
        r.planes  = planes;
        r.present = present;
        return r;
    endfunction

    function automatic plane_req_t random_req();
        plane_req_t r;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 50)
            r.op = bpp_pkg::OP_CONVERT;
        else if (pick < 70)
            r.op = bpp_pkg::OP_WR_RGB24;
        else if (pick < 90)
            r.op = bpp_pkg::OP_WR_RGB4;
        else
            r.op = OP_UNUSED;
        // low entries often, so later conversions read back fresh colors
        r.slot  = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
        r.color = 24'($urandom);
        for (int p = 0; p < 8; p++)
            r.planes[p] = 8'($urandom);
        r.present = $urandom_range(1) ? 8'hFF : 8'($urandom);
        return r;
    endfunction

    // block idle: nothing queued, offered or owed, plus a short settle
    task automatic drain();
        do
            @(negedge clk);
        while (req_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_depth(logic [3:0] planes);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= planes;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_depth = planes;
    endtask

    initial
    begin
        int         counted;
        plane_req_t r;
        palette_defaults();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // depth 4 from reset: indexes 0..7 over defaults, planes 4..7 cut off
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0,
                               64'hFFFF_FFFF_000F_3355, 8'hFF));
        // absent planes add nothing
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'h00));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'hF5));
        // palette writes at both ends of the table and the color range
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB24, 8'd0,   24'hFFFFFF, '0, 8'h00));
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB24, 8'd255, 24'h000000, '1, 8'hFF));
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB24, 8'd5,   24'h123456, '0, 8'h00));
        // short form: upper twelve bits must be ignored
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB4, 8'd4, 24'hFFFABC, '0, 8'h00));
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB4, 8'd6, 24'hABC000, '0, 8'h00));
        req_q.push_back(mk_req(bpp_pkg::OP_WR_RGB4, 8'd7, 24'h000FFF, '1, 8'hFF));
        // unused opcode must neither write nor emit
        req_q.push_back(mk_req(OP_UNUSED, 8'd5, 24'h0, '1, 8'hFF));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0,
                               64'hFFFF_FFFF_000F_3355, 8'hFF));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '0, 8'hFF));
        drain();

        // depth zero: every index 0
        set_depth(4'd0);
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'hFF));
        drain();

        // depth above the plane count behaves as eight planes
        set_depth(4'd15);
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'hFF));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0,
                               64'h5AA5_C33C_0FF0_9966, 8'hFF));
        drain();

        set_depth(4'd8);
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0,
                               64'h8000_0000_0000_0000, 8'hFF));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'h7F));
        drain();

        set_depth(4'd1);
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'hFE));
        req_q.push_back(mk_req(bpp_pkg::OP_CONVERT, 8'h00, 24'h0, '1, 8'h01));
        drain();

        // random phases, one at a new depth each; the second runs gap-free
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_depth(4'd8);
                1:       set_depth(4'd3);
                2:       set_depth(4'($urandom_range(15)));
                default: set_depth(4'd4);
            endcase
            steady  = (phase == 1);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = random_req();
                req_q.push_back(r);
                if (r.op != OP_UNUSED)
                    counted++;
            end
            drain();
        end
        steady = 1'b0;

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
